FILE: src/mrc_pkg.sv
// Shared types, constants and functions of the Modbus response checker.
// No dependencies; every other file refers to it by scoped names.
package mrc_pkg;

  localparam int ALARM_REGS = 33;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ADDR_RESET = 8'h01;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;
  localparam logic [7:0] FC_EXCEPTION_BIT = 8'h80;

  localparam logic [3:0] ST_DATA_OK = 4'd0;
  localparam logic [3:0] ST_EXCEPTION_OK = 4'd1;
  localparam logic [3:0] ST_ECHO_OK = 4'd2;
  localparam logic [3:0] ST_SHORT = 4'd3;
  localparam logic [3:0] ST_ADDRESS = 4'd4;
  localparam logic [3:0] ST_CRC = 4'd5;
  localparam logic [3:0] ST_ODD_COUNT = 4'd6;
  localparam logic [3:0] ST_LENGTH = 4'd7;
  localparam logic [3:0] ST_UNKNOWN_COUNT = 4'd8;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd9;

  localparam logic [2:0] STG_VERSION = 3'd0;
  localparam logic [2:0] STG_RUN_STATE = 3'd1;
  localparam logic [2:0] STG_SENSORS = 3'd2;
  localparam logic [2:0] STG_ALARMS = 3'd3;
  localparam logic [2:0] STG_PARAMETERS = 3'd4;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [6:0]            reg_index;
    logic [15:0]           reg_word;
    logic [3:0]            status;
    logic [2:0]            stage;
    logic [6:0]            regs_announced;
    logic [ALARM_REGS-1:0] alarm_bits;
  } event_t;

  typedef struct packed {
    logic       known;
    logic [2:0] stage;
  } stage_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic stage_t stage_of(input logic [6:0] regs);
    stage_t s;
    s.known = 1'b1;
    case (regs)
      7'd1: s.stage = STG_VERSION;
      7'd6: s.stage = STG_RUN_STATE;
      7'd9: s.stage = STG_SENSORS;
      7'd33: s.stage = STG_ALARMS;
      7'd11: s.stage = STG_PARAMETERS;
      default: begin
        s.known = 1'b0;
        s.stage = STG_VERSION;
      end
    endcase
    return s;
  endfunction

endpackage

FILE: src/modbus_response_checker.sv
// Top level of the Modbus RTU response checker: front end, event queue, output stage.
// Depends on mrc_pkg, mrc_front, mrc_queue and mrc_back.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid_i/cfg_ready_o cfg_data_i (slave address)
//  in       in         in_valid_i/in_ready_o   rx_byte_i, end_of_frame_i
//  out      out        out_valid_o/out_ready_i kind_o .. alarm_any_o
//
// One byte beat per cycle while in_ready_o is high; CRC and parsing finish in the
// cycle of acceptance. Results pass through the event queue and the output register.
// in_ready_o drops only while the four-entry event queue is full.
// Reset restores slave address 1 and clears the frame state; no clearing pass.
module modbus_response_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           end_of_frame_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [6:0]                     reg_index_o,
  output logic [15:0]                    reg_word_o,
  output logic [3:0]                     status_o,
  output logic [2:0]                     stage_o,
  output logic [6:0]                     regs_announced_o,
  output logic [mrc_pkg::ALARM_REGS-1:0] alarm_bits_o,
  output logic                           alarm_any_o
);

  logic            push, full, head_valid, pop;
  mrc_pkg::event_t push_ev, head_ev;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !full;

  mrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (in_valid_i && in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .push_o         (push),
    .event_o        (push_ev)
  );

  mrc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ev),
    .pop_i   (pop),
    .valid_o (head_valid),
    .full_o  (full),
    .data_o  (head_ev)
  );

  mrc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_i           (head_ev),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .reg_index_o      (reg_index_o),
    .reg_word_o       (reg_word_o),
    .status_o         (status_o),
    .stage_o          (stage_o),
    .regs_announced_o (regs_announced_o),
    .alarm_bits_o     (alarm_bits_o),
    .alarm_any_o      (alarm_any_o)
  );

  a_fail_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && (status_o != mrc_pkg::ST_DATA_OK)
    |-> (stage_o == mrc_pkg::STG_VERSION) && (alarm_bits_o == '0))
    else $error("failed verdict carries stage or alarms");

  a_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == mrc_pkg::KIND_WORD)
    |-> (status_o == mrc_pkg::ST_DATA_OK) && (regs_announced_o == 7'd0) && !alarm_any_o)
    else $error("word beat carries verdict fields");

  a_alarm_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_any_o |-> kind_o && (stage_o == mrc_pkg::STG_ALARMS))
    else $error("alarm flag outside alarm stage");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !$past(full) || $past(pop) || !full)
    else $error("event pushed into full queue");

endmodule

FILE: src/mrc_front.sv
// Front end: accepts frame bytes, runs the CRC and frame parsing, and classifies
// each byte into a register word event, a verdict event, or nothing. Uses mrc_pkg.
module mrc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                end_of_frame_i,
  output logic                push_o,
  output mrc_pkg::event_t     event_o
);

  logic [7:0]                      addr_q;
  logic [8:0]                      pos_q, pos_d;
  logic [15:0]                     crc_q, crc_d, crc_n;
  logic                            am_q, am_d, am_n;
  logic [7:0]                      fc_q, fc_d, fc_n;
  logic [7:0]                      bc_q, bc_d, bc_n;
  logic [7:0]                      hi_q, hi_d;
  logic [6:0]                      wc_q, wc_d;
  logic [mrc_pkg::ALARM_REGS-1:0]  alarm_q, alarm_d;

  logic [9:0]      len;
  logic            in_data;
  logic [15:0]     word;
  logic [3:0]      status;
  logic [6:0]      rc;
  mrc_pkg::stage_t stg;

  always_comb begin
    crc_n = mrc_pkg::crc_byte(crc_q, rx_byte_i);
    am_n  = (pos_q == 9'd0) ? (rx_byte_i == addr_q) : am_q;
    fc_n  = (pos_q == 9'd1) ? rx_byte_i : fc_q;
    bc_n  = (pos_q == 9'd2) ? rx_byte_i : bc_q;
    word  = {hi_q, rx_byte_i};
    len   = {1'b0, pos_q} + 10'd1;
    in_data = (pos_q >= 9'd3) && ({1'b0, pos_q} < (10'd3 + {2'b00, bc_n}))
              && (fc_n == mrc_pkg::FC_READ_HOLDING) && am_n;

    rc  = 7'd0;
    stg = mrc_pkg::stage_of(bc_n[7:1]);
    if (len < 10'd5) begin
      status = mrc_pkg::ST_SHORT;
    end else if (!am_n) begin
      status = mrc_pkg::ST_ADDRESS;
    end else if ((fc_n & mrc_pkg::FC_EXCEPTION_BIT) != 8'h00) begin
      status = (crc_n == 16'h0000) ? mrc_pkg::ST_EXCEPTION_OK : mrc_pkg::ST_CRC;
    end else if (fc_n == mrc_pkg::FC_READ_HOLDING) begin
      rc = bc_n[7:1];
      if (crc_n != 16'h0000) status = mrc_pkg::ST_CRC;
      else if (bc_n[0]) status = mrc_pkg::ST_ODD_COUNT;
      else if (len != (10'd5 + {2'b00, bc_n})) status = mrc_pkg::ST_LENGTH;
      else if (!stg.known) status = mrc_pkg::ST_UNKNOWN_COUNT;
      else status = mrc_pkg::ST_DATA_OK;
    end else if ((fc_n == mrc_pkg::FC_WRITE_SINGLE) || (fc_n == mrc_pkg::FC_WRITE_MULTI)) begin
      if (len != 10'd8) status = mrc_pkg::ST_LENGTH;
      else if (crc_n != 16'h0000) status = mrc_pkg::ST_CRC;
      else status = mrc_pkg::ST_ECHO_OK;
    end else begin
      status = mrc_pkg::ST_UNSUPPORTED;
    end

    event_o = '0;
    push_o  = 1'b0;
    pos_d   = pos_q;
    crc_d   = crc_q;
    am_d    = am_q;
    fc_d    = fc_q;
    bc_d    = bc_q;
    hi_d    = hi_q;
    wc_d    = wc_q;
    alarm_d = alarm_q;

    if (accept_i && end_of_frame_i) begin
      push_o = 1'b1;
      event_o.kind = mrc_pkg::KIND_VERDICT;
      event_o.status = status;
      event_o.regs_announced = rc;
      if (status == mrc_pkg::ST_DATA_OK) begin
        event_o.stage = stg.stage;
        if (stg.stage == mrc_pkg::STG_ALARMS) event_o.alarm_bits = alarm_q;
      end
      pos_d   = '0;
      crc_d   = mrc_pkg::CRC_INIT;
      am_d    = 1'b0;
      fc_d    = '0;
      bc_d    = '0;
      hi_d    = '0;
      wc_d    = '0;
      alarm_d = '0;
    end else if (accept_i) begin
      crc_d = crc_n;
      am_d  = am_n;
      fc_d  = fc_n;
      bc_d  = bc_n;
      if (pos_q != 9'd511) pos_d = pos_q + 9'd1;
      if (in_data) begin
        if (pos_q[0]) begin
          hi_d = rx_byte_i;
        end else begin
          push_o = 1'b1;
          event_o.kind = mrc_pkg::KIND_WORD;
          event_o.reg_index = wc_q;
          event_o.reg_word = word;
          wc_d = wc_q + 7'd1;
          if (word != 16'h0000) begin
            alarm_d = alarm_q | (mrc_pkg::ALARM_REGS'(1) << wc_q);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= mrc_pkg::ADDR_RESET;
      pos_q   <= '0;
      crc_q   <= mrc_pkg::CRC_INIT;
      am_q    <= 1'b0;
      fc_q    <= '0;
      bc_q    <= '0;
      hi_q    <= '0;
      wc_q    <= '0;
      alarm_q <= '0;
    end else begin
      if (cfg_valid_i) addr_q <= cfg_data_i;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      am_q    <= am_d;
      fc_q    <= fc_d;
      bc_q    <= bc_d;
      hi_q    <= hi_d;
      wc_q    <= wc_d;
      alarm_q <= alarm_d;
    end
  end

endmodule

FILE: src/mrc_queue.sv
// Short FIFO of classified events between the front end and the output stage.
// Uses mrc_pkg for the event type and depth.
module mrc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrc_pkg::event_t data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output logic            full_o,
  output mrc_pkg::event_t data_o
);

  mrc_pkg::event_t                mem_q [mrc_pkg::QUEUE_DEPTH];
  logic [mrc_pkg::QUEUE_AW-1:0]   wr_q, rd_q;
  logic [mrc_pkg::QUEUE_AW:0]     cnt_q;
  logic                           do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (mrc_pkg::QUEUE_AW+1)'(mrc_pkg::QUEUE_DEPTH));
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      case ({push_i, do_pop})
        2'b10: cnt_q <= cnt_q + 1'b1;
        2'b01: cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/mrc_back.sv
// Output stage: takes events from the queue, derives the alarm summary and
// holds each result beat until the sink takes it. Uses mrc_pkg.
module mrc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  mrc_pkg::event_t                head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           kind_o,
  output logic [6:0]                     reg_index_o,
  output logic [15:0]                    reg_word_o,
  output logic [3:0]                     status_o,
  output logic [2:0]                     stage_o,
  output logic [6:0]                     regs_announced_o,
  output logic [mrc_pkg::ALARM_REGS-1:0] alarm_bits_o,
  output logic                           alarm_any_o
);

  logic            valid_q;
  mrc_pkg::event_t ev_q;
  logic            any_q;
  logic            load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = head_valid_i && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q  <= head_i;
      any_q <= (head_i.alarm_bits != '0);
    end
  end

  assign out_valid_o      = valid_q;
  assign kind_o           = ev_q.kind;
  assign reg_index_o      = ev_q.reg_index;
  assign reg_word_o       = ev_q.reg_word;
  assign status_o         = ev_q.status;
  assign stage_o          = ev_q.stage;
  assign regs_announced_o = ev_q.regs_announced;
  assign alarm_bits_o     = ev_q.alarm_bits;
  assign alarm_any_o      = any_q;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for modbus_response_checker: sends response frames byte by byte
// and checks every word and verdict beat against a scoreboard that predicts them.
// Depends on mrc_pkg and the RTL under src.
module testbench;

  typedef struct packed {
    logic                           kind;
    logic [6:0]                     reg_index;
    logic [15:0]                    reg_word;
    logic [3:0]                     status;
    logic [2:0]                     stage;
    logic [6:0]                     regs_announced;
    logic [mrc_pkg::ALARM_REGS-1:0] alarm_bits;
    logic                           alarm_any;
  } reply_t;

  class reply_scoreboard;
    logic [7:0]                     slave_addr;
    int unsigned                    pos;
    logic [15:0]                    crc;
    logic                           addr_ok;
    logic [7:0]                     fcode;
    logic [7:0]                     bcount;
    logic [7:0]                     hi_byte;
    logic [6:0]                     wcnt;
    logic [mrc_pkg::ALARM_REGS-1:0] alarms;
    reply_t                         expected_replies[$];
    int unsigned                    mismatches;

    function new();
      slave_addr = mrc_pkg::ADDR_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ mrc_pkg::CRC_POLY) : {1'b0, r[15:1]};
      return r;
    endfunction

    function void clear_frame();
      pos = 0;
      crc = mrc_pkg::CRC_INIT;
      addr_ok = 1'b0;
      fcode = '0;
      bcount = '0;
      hi_byte = '0;
      wcnt = '0;
      alarms = '0;
    endfunction

    function void set_slave_address(logic [7:0] a);
      slave_addr = a;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function void note_rx_byte(logic [7:0] b, logic last);
      reply_t      r;
      logic [15:0] w;
      int unsigned len;
      crc = crc_step(crc, b);
      if (pos == 0) addr_ok = (b == slave_addr);
      else if (pos == 1) fcode = b;
      else if (pos == 2) bcount = b;
      if (!last) begin
        if (pos >= 3 && pos < 3 + bcount && fcode == mrc_pkg::FC_READ_HOLDING
            && addr_ok) begin
          if ((pos - 3) % 2 == 0) begin
            hi_byte = b;
          end else begin
            w = {hi_byte, b};
            if (w != 0 && wcnt < mrc_pkg::ALARM_REGS) alarms[wcnt] = 1'b1;
            r = '0;
            r.kind = mrc_pkg::KIND_WORD;
            r.reg_index = wcnt;
            r.reg_word = w;
            expected_replies.insert(expected_replies.size(), r);
            wcnt++;
          end
        end
        if (pos < 511) pos++;
        return;
      end
      r = '0;
      r.kind = mrc_pkg::KIND_VERDICT;
      len = pos + 1;
      if (len < 5) begin
        r.status = mrc_pkg::ST_SHORT;
      end else if (!addr_ok) begin
        r.status = mrc_pkg::ST_ADDRESS;
      end else if ((fcode & mrc_pkg::FC_EXCEPTION_BIT) != 0) begin
        r.status = (crc == 0) ? mrc_pkg::ST_EXCEPTION_OK : mrc_pkg::ST_CRC;
      end else if (fcode == mrc_pkg::FC_READ_HOLDING) begin
        r.regs_announced = bcount[7:1];
        if (crc != 0) r.status = mrc_pkg::ST_CRC;
        else if (bcount[0]) r.status = mrc_pkg::ST_ODD_COUNT;
        else if (len != 5 + bcount) r.status = mrc_pkg::ST_LENGTH;
        else begin
          r.status = mrc_pkg::ST_DATA_OK;
          case (bcount[7:1])
            7'd1: r.stage = mrc_pkg::STG_VERSION;
            7'd6: r.stage = mrc_pkg::STG_RUN_STATE;
            7'd9: r.stage = mrc_pkg::STG_SENSORS;
            7'd11: r.stage = mrc_pkg::STG_PARAMETERS;
            7'd33: begin
              r.stage = mrc_pkg::STG_ALARMS;
              r.alarm_bits = alarms;
              r.alarm_any = |alarms;
            end
            default: r.status = mrc_pkg::ST_UNKNOWN_COUNT;
          endcase
        end
      end else if (fcode == mrc_pkg::FC_WRITE_SINGLE || fcode == mrc_pkg::FC_WRITE_MULTI) begin
        if (len != 8) r.status = mrc_pkg::ST_LENGTH;
        else if (crc != 0) r.status = mrc_pkg::ST_CRC;
        else r.status = mrc_pkg::ST_ECHO_OK;
      end else begin
        r.status = mrc_pkg::ST_UNSUPPORTED;
      end
      expected_replies.insert(expected_replies.size(), r);
      clear_frame();
    endfunction

    function string describe(reply_t r);
      return $sformatf({"kind %0d index %0d word %h status %0d stage %0d count %0d",
                        " alarms %h any %0d"},
                       r.kind, r.reg_index, r.reg_word, r.status, r.stage, r.regs_announced,
                       r.alarm_bits, r.alarm_any);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %s", describe(got));
        return;
      end
      want = expected_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %s / got %s", describe(want), describe(got));
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [7:0]                     cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [7:0]                     rx_byte_i = '0;
  logic                           end_of_frame_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           kind_o;
  logic [6:0]                     reg_index_o;
  logic [15:0]                    reg_word_o;
  logic [3:0]                     status_o;
  logic [2:0]                     stage_o;
  logic [6:0]                     regs_announced_o;
  logic [mrc_pkg::ALARM_REGS-1:0] alarm_bits_o;
  logic                           alarm_any_o;

  logic                           idle_on = 1'b1;
  int                             hold_req = 0;
  logic [7:0]                     frame_bytes[$];
  reply_scoreboard                sb;

  modbus_response_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .end_of_frame_i   (end_of_frame_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .reg_index_o      (reg_index_o),
    .reg_word_o       (reg_word_o),
    .status_o         (status_o),
    .stage_o          (stage_o),
    .regs_announced_o (regs_announced_o),
    .alarm_bits_o     (alarm_bits_o),
    .alarm_any_o      (alarm_any_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  function automatic void append_crc();
    logic [15:0] c;
    c = mrc_pkg::CRC_INIT;
    foreach (frame_bytes[i]) c = reply_scoreboard::crc_step(c, frame_bytes[i]);
    add_byte(c[7:0]);
    add_byte(c[15:8]);
  endfunction

  function automatic void build_read_reply(input logic [7:0] addr, input int unsigned regs);
    logic        quiet;
    logic [15:0] w;
    quiet = ($urandom_range(3) == 0);
    frame_bytes = '{addr, mrc_pkg::FC_READ_HOLDING, 8'(2 * regs)};
    repeat (regs) begin
      case ($urandom_range(3))
        0: w = '0;
        1: w = '1;
        default: w = 16'($urandom);
      endcase
      if (quiet) w = '0;
      add_byte(w[15:8]);
      add_byte(w[7:0]);
    end
    append_crc();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    end_of_frame_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_rx_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic write_slave_address(input logic [7:0] a);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= a;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.set_slave_address(a);
  endtask

  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic make_random_frame(input logic [7:0] addr);
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    logic [7:0]  fc;
    int unsigned known_sizes[5];
    known_sizes = '{1, 6, 9, 33, 11};
    sel = $urandom_range(99);
    if ($urandom_range(9) == 0) addr = addr ^ 8'($urandom_range(255, 1));
    if (sel < 55) begin
      if ($urandom_range(7) == 0) n = $urandom_range(20);
      else n = known_sizes[$urandom_range(4)];
      build_read_reply(addr, n);
    end else if (sel < 65) begin
      frame_bytes = '{addr, mrc_pkg::FC_EXCEPTION_BIT | 8'($urandom_range(127)), 8'($urandom)};
      append_crc();
    end else if (sel < 75) begin
      fc = $urandom_range(1) ? mrc_pkg::FC_WRITE_SINGLE : mrc_pkg::FC_WRITE_MULTI;
      frame_bytes = '{addr, fc};
      repeat (4) add_byte(8'($urandom));
      append_crc();
    end else if (sel < 82) begin
      frame_bytes = '{addr, 8'($urandom_range(127))};
      repeat ($urandom_range(6)) add_byte(8'($urandom));
      append_crc();
    end else begin
      frame_bytes.delete();
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
      if ($urandom_range(1)) frame_bytes[0] = addr;
    end
    if (sel < 82 && $urandom_range(99) < 30) begin
      case ($urandom_range(4))
        0: begin
          k = $urandom_range(frame_bytes.size() - 1);
          frame_bytes[k] = frame_bytes[k] ^ 8'(1 << $urandom_range(7));
        end
        1: begin
          n = $urandom_range(3, 1);
          while (n != 0 && frame_bytes.size() > 1) begin
            void'(frame_bytes.pop_back());
            n--;
          end
        end
        2: repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
        3: begin
          if (frame_bytes.size() > 4) begin
            void'(frame_bytes.pop_back());
            void'(frame_bytes.pop_back());
            frame_bytes[2] = frame_bytes[2] ^ 8'h01;
            append_crc();
          end
        end
        default: begin
          void'(frame_bytes.pop_back());
          void'(frame_bytes.pop_back());
          if ($urandom_range(1) && frame_bytes.size() > 3) void'(frame_bytes.pop_back());
          else add_byte(8'($urandom));
          append_crc();
        end
      endcase
    end
  endtask

  // result side: check accepted beats, then choose ready for the next cycle
  initial begin
    reply_t      got;
    int unsigned hold_left;
    int          hold_seen;
    hold_left = 0;
    hold_seen = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = {kind_o, reg_index_o, reg_word_o, status_o, stage_o, regs_announced_o,
               alarm_bits_o, alarm_any_o};
        sb.check_reply(got);
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 120;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 17);
      end
    end
  end

  initial begin
    logic [7:0]  phase_addr[5];
    int unsigned phase_bytes;
    sb = new();
    phase_addr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), mrc_pkg::ADDR_RESET};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    frame_bytes = '{mrc_pkg::ADDR_RESET, mrc_pkg::FC_EXCEPTION_BIT | mrc_pkg::FC_READ_HOLDING,
                    8'h02};
    append_crc();
    send_frame();
    frame_bytes = '{mrc_pkg::ADDR_RESET, mrc_pkg::FC_WRITE_SINGLE, 8'h00, 8'h01, 8'h00, 8'hFF};
    append_crc();
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'h00};
    send_frame();
    frame_bytes = '{mrc_pkg::ADDR_RESET, mrc_pkg::FC_READ_HOLDING, 8'h02, 8'hFF, 8'hFF};
    append_crc();
    send_frame();
    wait_for_replies();

    for (int p = 0; p < 5; p++) begin
      write_slave_address(phase_addr[p]);
      idle_on <= (p != 2);
      if (p == 1) begin
        // stall the result side while a long reply keeps arriving
        hold_req <= hold_req + 1;
        build_read_reply(phase_addr[p], 33);
        send_frame();
      end
      if (p == 3) begin
        frame_bytes = '{phase_addr[p], mrc_pkg::FC_READ_HOLDING, 8'($urandom_range(255, 200))};
        repeat ($urandom_range(560, 517)) add_byte(8'($urandom));
        send_frame();
      end
      phase_bytes = 0;
      while (phase_bytes < 220) begin
        make_random_frame(phase_addr[p]);
        phase_bytes += frame_bytes.size();
        send_frame();
      end
      wait_for_replies();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
